// ===== rtl/ack_rgf_pkg.sv =====
package ack_rgf_pkg;

  // fixed field widths
  localparam int unsigned NumGateways = 3;
  localparam int unsigned MaskW       = 3;
  localparam int unsigned GwW         = 2;
  localparam int unsigned AttW        = $clog2(NumGateways + 1);
  localparam int unsigned RetryW      = 4;
  localparam int unsigned TickW       = 16;
  localparam int unsigned TimerW      = TickW + (1 << RetryW) - 1;
  localparam int unsigned SeqW        = 32;
  localparam int unsigned CntW        = 32;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  // register reset values
  localparam logic [MaskW-1:0]  MaskReset    = MaskW'(1);
  localparam logic [RetryW-1:0] RetriesReset = RetryW'(2);
  localparam logic [TickW-1:0]  TimeoutReset = TickW'(500);
  localparam logic [TickW-1:0]  BaseReset    = TickW'(100);

  typedef enum logic [2:0] {
    CmdStart  = 3'd0,
    CmdAccept = 3'd1,
    CmdReject = 3'd2,
    CmdAck    = 3'd3,
    CmdTick   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhSend    = 2'd1,
    PhAck     = 2'd2,
    PhBackoff = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ActSend = 2'd0,
    ActDone = 2'd1,
    ActFail = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegMask    = 2'd0,
    RegRetries = 2'd1,
    RegTimeout = 2'd2,
    RegBase    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [MaskW-1:0]  mask;
    logic [RetryW-1:0] retries;
    logic [TickW-1:0]  timeout;
    logic [TickW-1:0]  base;
  } cfg_t;

  typedef struct packed {
    phase_e             phase;
    logic [GwW-1:0]     last_good;
    logic [GwW-1:0]     first_gw;
    logic [AttW-1:0]    att_idx;
    logic [GwW-1:0]     cur_gw;
    logic [RetryW-1:0]  retry_idx;
    logic [TimerW-1:0]  timer;
    logic [SeqW-1:0]    exp_seq;
    logic [CntW-1:0]    att_cnt;
    logic [CntW-1:0]    succ_cnt;
    logic [CntW-1:0]    fail_cnt;
  } state_t;

  typedef struct packed {
    action_e           action;
    logic [GwW-1:0]    gateway;
    logic [RetryW-1:0] retry;
    logic              store;
  } result_t;

endpackage

// ===== rtl/ack_retry_gateway_failover_core.sv =====
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    command_i, seq_i
// out       output     out_valid_o / out_ready_i  action_o, gateway_o, retry_o,
//                                                 store_last_gateway_o, attempt_cnt_o,
//                                                 success_cnt_o, failure_cnt_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one request per cycle sustained while out_ready_i is not held low; a result is written to
// the result register after the request passes the input register and the combinational
// state update. the rate is set by the state update loop.
// reset puts the configuration registers at their defaults and the controller idle, no clearing pass.
// a stalled result holds the pipe only once the input register is also full.
module ack_retry_gateway_failover_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [2:0]                           command_i,
  input  logic [ack_rgf_pkg::SeqW-1:0]         seq_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           action_o,
  output logic [ack_rgf_pkg::GwW-1:0]          gateway_o,
  output logic [ack_rgf_pkg::RetryW-1:0]       retry_o,
  output logic                                 store_last_gateway_o,
  output logic [ack_rgf_pkg::CntW-1:0]         attempt_cnt_o,
  output logic [ack_rgf_pkg::CntW-1:0]         success_cnt_o,
  output logic [ack_rgf_pkg::CntW-1:0]         failure_cnt_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ack_rgf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [ack_rgf_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic                               in_valid_q;
  logic [2:0]                         cmd_q;
  logic [ack_rgf_pkg::SeqW-1:0]       seq_q;
  ack_rgf_pkg::state_t                state_q;
  ack_rgf_pkg::state_t                state_d;
  ack_rgf_pkg::cfg_t                  cfg_q;
  ack_rgf_pkg::result_t               res_d;
  ack_rgf_pkg::result_t               res_q;
  logic                               emit_d;
  logic                               out_valid_q;
  logic [ack_rgf_pkg::CntW-1:0]       att_q;
  logic [ack_rgf_pkg::CntW-1:0]       succ_q;
  logic [ack_rgf_pkg::CntW-1:0]       fail_q;
  logic                               fire;

  // process the staged request once the result slot is free
  assign fire        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || fire;
  assign cfg_ready_o = 1'b1;

  ack_rgf_step u_step (
    .st_i   (state_q),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd_q),
    .seq_i  (seq_q),
    .nxt_o  (state_d),
    .emit_o (emit_d),
    .res_o  (res_d)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      seq_q <= seq_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mask    <= ack_rgf_pkg::MaskReset;
      cfg_q.retries <= ack_rgf_pkg::RetriesReset;
      cfg_q.timeout <= ack_rgf_pkg::TimeoutReset;
      cfg_q.base    <= ack_rgf_pkg::BaseReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ack_rgf_pkg::cfg_reg_e'(cfg_index_i))
        ack_rgf_pkg::RegMask:    cfg_q.mask    <= cfg_data_i[ack_rgf_pkg::MaskW-1:0];
        ack_rgf_pkg::RegRetries: cfg_q.retries <= cfg_data_i[ack_rgf_pkg::RetryW-1:0];
        ack_rgf_pkg::RegTimeout: cfg_q.timeout <= cfg_data_i[ack_rgf_pkg::TickW-1:0];
        ack_rgf_pkg::RegBase:    cfg_q.base    <= cfg_data_i[ack_rgf_pkg::TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  // controller state, all-zero is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit_d) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit_d) begin
      res_q  <= res_d;
      att_q  <= state_d.att_cnt;
      succ_q <= state_d.succ_cnt;
      fail_q <= state_d.fail_cnt;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign action_o             = res_q.action;
  assign gateway_o            = res_q.gateway;
  assign retry_o              = res_q.retry;
  assign store_last_gateway_o = res_q.store;
  assign attempt_cnt_o        = att_q;
  assign success_cnt_o        = succ_q;
  assign failure_cnt_o        = fail_q;

  // a failure result carries the bumped failure count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit_d && res_d.action == ack_rgf_pkg::ActFail) |=>
      (failure_cnt_o == $past(state_q.fail_cnt) + ack_rgf_pkg::CntW'(1)))
    else $error("failure count not advanced with failure result");

  // a send result leaves the controller awaiting accept or reject
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit_d && res_d.action == ack_rgf_pkg::ActSend) |=>
      (state_q.phase == ack_rgf_pkg::PhSend))
    else $error("send issued without entering send pending");

  // store flag only on delivery
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && store_last_gateway_o) |-> (action_o == ack_rgf_pkg::ActDone))
    else $error("store flag on non-delivery result");

  // a staged request that cannot proceed is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(cmd_q) && $stable(seq_q)))
    else $error("staged request lost while result stalled");

endmodule

// ===== rtl/ack_rgf_step.sv =====
module ack_rgf_step (
  input  ack_rgf_pkg::state_t                 st_i,
  input  ack_rgf_pkg::cfg_t                   cfg_i,
  input  logic [2:0]                          cmd_i,
  input  logic [ack_rgf_pkg::SeqW-1:0]        seq_i,
  output ack_rgf_pkg::state_t                 nxt_o,
  output logic                                emit_o,
  output ack_rgf_pkg::result_t                res_o
);

  typedef struct packed {
    logic                              found;
    logic [ack_rgf_pkg::AttW-1:0]      att;
    logic [ack_rgf_pkg::GwW-1:0]       gw;
  } seek_t;

  // round-robin search for the first valid gateway at or after position from
  function automatic seek_t seek(input logic [ack_rgf_pkg::AttW-1:0]  from,
                                 input logic [ack_rgf_pkg::GwW-1:0]   start,
                                 input logic [ack_rgf_pkg::MaskW-1:0] mask);
    seek_t                         r;
    logic [ack_rgf_pkg::GwW:0]     g;
    r = '0;
    for (int a = ack_rgf_pkg::NumGateways - 1; a >= 0; a--) begin
      g = {1'b0, start} + (ack_rgf_pkg::GwW + 1)'(a);
      if (g >= (ack_rgf_pkg::GwW + 1)'(ack_rgf_pkg::NumGateways)) begin
        g = g - (ack_rgf_pkg::GwW + 1)'(ack_rgf_pkg::NumGateways);
      end
      if ((a >= int'(from)) && (g < (ack_rgf_pkg::GwW + 1)'(ack_rgf_pkg::MaskW)) &&
          mask[g[ack_rgf_pkg::GwW-1:0]]) begin
        r.found = 1'b1;
        r.att   = ack_rgf_pkg::AttW'(a);
        r.gw    = g[ack_rgf_pkg::GwW-1:0];
      end
    end
    return r;
  endfunction

  logic                              do_backoff;
  logic                              do_advance;
  logic                              do_seek;
  logic [ack_rgf_pkg::AttW-1:0]      seek_from;
  logic [ack_rgf_pkg::TimerW-1:0]    tick_t;
  logic [ack_rgf_pkg::TimerW-1:0]    boff_t;
  logic [ack_rgf_pkg::RetryW:0]      retry_nx;
  seek_t                             sk;

  always_comb begin
    nxt_o      = st_i;
    emit_o     = 1'b0;
    res_o      = '0;
    do_backoff = 1'b0;
    do_advance = 1'b0;
    do_seek    = 1'b0;
    seek_from  = '0;
    tick_t     = st_i.timer;
    boff_t     = '0;
    retry_nx   = {1'b0, st_i.retry_idx} + (ack_rgf_pkg::RetryW + 1)'(1);
    sk         = '0;

    // decode the request
    unique case (ack_rgf_pkg::cmd_e'(cmd_i))
      ack_rgf_pkg::CmdStart: begin
        if (st_i.phase == ack_rgf_pkg::PhIdle) begin
          nxt_o.att_cnt = st_i.att_cnt + ack_rgf_pkg::CntW'(1);
          nxt_o.exp_seq = seq_i;
          nxt_o.first_gw = ({1'b0, st_i.last_good} <
                            (ack_rgf_pkg::GwW + 1)'(ack_rgf_pkg::NumGateways)) ?
                           st_i.last_good : '0;
          do_seek = 1'b1;
        end
      end
      ack_rgf_pkg::CmdAccept: begin
        if (st_i.phase == ack_rgf_pkg::PhSend) begin
          nxt_o.timer = '0;
          nxt_o.phase = ack_rgf_pkg::PhAck;
        end
      end
      ack_rgf_pkg::CmdReject: begin
        do_backoff = (st_i.phase == ack_rgf_pkg::PhSend);
      end
      ack_rgf_pkg::CmdAck: begin
        if ((st_i.phase == ack_rgf_pkg::PhAck) && (seq_i == st_i.exp_seq)) begin
          nxt_o.succ_cnt  = st_i.succ_cnt + ack_rgf_pkg::CntW'(1);
          nxt_o.last_good = st_i.cur_gw;
          nxt_o.phase     = ack_rgf_pkg::PhIdle;
          emit_o          = 1'b1;
          res_o.action    = ack_rgf_pkg::ActDone;
          res_o.gateway   = st_i.cur_gw;
          res_o.retry     = st_i.retry_idx;
          res_o.store     = (st_i.cur_gw != st_i.first_gw);
        end
      end
      ack_rgf_pkg::CmdTick: begin
        if (st_i.phase == ack_rgf_pkg::PhAck) begin
          tick_t      = st_i.timer + ack_rgf_pkg::TimerW'(1);
          nxt_o.timer = tick_t;
          do_backoff  = (tick_t >= ack_rgf_pkg::TimerW'(cfg_i.timeout));
        end else if (st_i.phase == ack_rgf_pkg::PhBackoff) begin
          if (st_i.timer != '0) begin
            tick_t = st_i.timer - ack_rgf_pkg::TimerW'(1);
          end
          nxt_o.timer = tick_t;
          do_advance  = (tick_t == '0);
        end
      end
      default: begin
      end
    endcase

    // backoff start, zero length falls straight through
    if (do_backoff) begin
      boff_t      = ack_rgf_pkg::TimerW'(cfg_i.base) << st_i.retry_idx;
      nxt_o.timer = boff_t;
      if (boff_t == '0) begin
        do_advance = 1'b1;
      end else begin
        nxt_o.phase = ack_rgf_pkg::PhBackoff;
      end
    end

    // next retry on this gateway or fail over
    if (do_advance) begin
      if (retry_nx < {1'b0, cfg_i.retries}) begin
        nxt_o.retry_idx = retry_nx[ack_rgf_pkg::RetryW-1:0];
        nxt_o.phase     = ack_rgf_pkg::PhSend;
        emit_o          = 1'b1;
        res_o.action    = ack_rgf_pkg::ActSend;
        res_o.gateway   = st_i.cur_gw;
        res_o.retry     = retry_nx[ack_rgf_pkg::RetryW-1:0];
      end else begin
        do_seek   = 1'b1;
        seek_from = st_i.att_idx + ack_rgf_pkg::AttW'(1);
      end
    end

    // gateway search
    if (do_seek) begin
      sk     = seek(seek_from, nxt_o.first_gw, cfg_i.mask);
      emit_o = 1'b1;
      if (sk.found) begin
        nxt_o.att_idx   = sk.att;
        nxt_o.cur_gw    = sk.gw;
        nxt_o.retry_idx = '0;
        nxt_o.phase     = ack_rgf_pkg::PhSend;
        res_o.action    = ack_rgf_pkg::ActSend;
        res_o.gateway   = sk.gw;
      end else begin
        nxt_o.att_idx  = '0;
        nxt_o.fail_cnt = st_i.fail_cnt + ack_rgf_pkg::CntW'(1);
        nxt_o.phase    = ack_rgf_pkg::PhIdle;
        res_o.action   = ack_rgf_pkg::ActFail;
      end
    end
  end

endmodule
